### rtl/nnd_pkg.sv
// nnd_pkg: shared types and constants for the nearest-neighbor downscaler
// sizes, fixed-point layout, reciprocal constants and payload structs
// no dependencies
package nnd_pkg;

  localparam int unsigned OutWidth  = 360;
  localparam int unsigned OutHeight = 236;
  localparam int unsigned DimBits   = 12;

  localparam int unsigned FracBits = 16;
  localparam int unsigned AccW     = FracBits + DimBits;
  localparam int unsigned OcolW    = $clog2(OutWidth + 1);
  localparam int unsigned OrowW    = $clog2(OutHeight + 1);

  // reciprocal scaling: quotient estimate is (size * rcp) >> RcpShift
  localparam int unsigned RcpShift = DimBits;
  localparam int unsigned RcpW     = FracBits + RcpShift + 1;
  localparam int unsigned ProdW    = DimBits + RcpW;
  localparam int unsigned BackW    = AccW + DimBits;

  localparam logic [63:0] RcpColL = (64'd1 << (FracBits + RcpShift)) / 64'(OutWidth);
  localparam logic [63:0] RcpRowL = (64'd1 << (FracBits + RcpShift)) / 64'(OutHeight);
  localparam logic [RcpW-1:0] RcpCol = RcpColL[RcpW-1:0];
  localparam logic [RcpW-1:0] RcpRow = RcpRowL[RcpW-1:0];

  localparam logic [63:0] DimMaskL = (64'd1 << DimBits) - 64'd1;

  // reset sizes and the steps that follow from them
  localparam logic [63:0] RstWidthL  = 64'd640 & DimMaskL;
  localparam logic [63:0] RstHeightL = 64'd480 & DimMaskL;
  localparam logic [63:0] RstEffWL   =
      (RstWidthL < 64'(OutWidth)) ? 64'(OutWidth) : RstWidthL;
  localparam logic [63:0] RstEffHL   =
      (RstHeightL < 64'(OutHeight)) ? 64'(OutHeight) : RstHeightL;
  localparam logic [63:0] RstColStepL = (RstEffWL << FracBits) / 64'(OutWidth);
  localparam logic [63:0] RstRowStepL = (RstEffHL << FracBits) / 64'(OutHeight);

  localparam logic [DimBits-1:0] RstEffW    = RstEffWL[DimBits-1:0];
  localparam logic [AccW-1:0]    RstColStep = RstColStepL[AccW-1:0];
  localparam logic [AccW-1:0]    RstRowStep = RstRowStepL[AccW-1:0];

  typedef enum logic {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_MUL,
    STEP_QUO,
    STEP_BACK,
    STEP_FIX
  } step_state_e;

  typedef struct packed {
    logic [15:0] pixel_in;
    logic        frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        frame_last;
  } pix_out_t;

endpackage

### rtl/nearest_neighbor_downscaler.sv
// Nearest-neighbor RGB565 downscaler to a fixed output frame of OutWidth x OutHeight.
// Throughput is one source pixel per clock while no step recompute runs and the skid entry is empty;
// each pixel gives zero or one output pixel, registered in an output register with a skid entry.
// After a size register write, input and configuration are held off while the sequencer
// steps through MUL, QUO, BACK and FIX and the 12.16 step for that axis is recomputed
// (multiply by reciprocal, back-multiply, one-step correction). Depends on nnd_pkg.
module nearest_neighbor_downscaler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  nnd_pkg::pix_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output nnd_pkg::pix_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  nnd_pkg::cfg_reg_e         cfg_index_i,
  input  logic [nnd_pkg::DimBits-1:0] cfg_data_i
);
  import nnd_pkg::*;

  // step recompute sequencer
  step_state_e              step_state_q, step_state_d;
  cfg_reg_e                 axis_q;
  logic [DimBits-1:0]       size_q;
  logic [ProdW-1:0]         prod_q;
  logic [AccW-1:0]          quo_q;
  logic [AccW-1:0]          back_q;
  logic [AccW-1:0]          col_step_q, row_step_q;
  logic [DimBits-1:0]       eff_w_q;
  logic                     busy;
  logic                     cfg_fire;
  logic [DimBits-1:0]       cfg_eff;
  logic [RcpW-1:0]          rcp_sel;
  logic [DimBits-1:0]       out_sel;
  logic [BackW-1:0]         back_full;
  logic [AccW-1:0]          rem;
  logic [AccW-1:0]          step_fix;

  // pixel path
  logic [DimBits-1:0]       src_col_q, src_row_q, src_col_d, src_row_d;
  logic [AccW-1:0]          col_acc_q, row_acc_q, col_acc_d, row_acc_d;
  logic [OcolW-1:0]         out_col_q, out_col_d;
  logic [OrowW-1:0]         out_row_q, out_row_d;
  logic [DimBits-1:0]       sc, sr;
  logic [AccW-1:0]          cacc, racc;
  logic [OcolW-1:0]         ocol;
  logic [OrowW-1:0]         orow;
  logic                     row_hit, hit, in_fire, produce;
  pix_out_t                 res;
  pix_out_t                 out_q, skid_q;
  logic                     out_valid_q, skid_valid_q;

  assign busy        = (step_state_q != STEP_IDLE);
  assign cfg_ready_o = !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !busy && !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_index_i == REG_SOURCE_WIDTH) begin
      cfg_eff = (cfg_data_i < DimBits'(OutWidth)) ? DimBits'(OutWidth) : cfg_data_i;
    end else begin
      cfg_eff = (cfg_data_i < DimBits'(OutHeight)) ? DimBits'(OutHeight) : cfg_data_i;
    end
  end

  always_comb begin
    step_state_d = step_state_q;
    case (step_state_q)
      STEP_IDLE: if (cfg_fire) step_state_d = STEP_MUL;
      STEP_MUL:  step_state_d = STEP_QUO;
      STEP_QUO:  step_state_d = STEP_BACK;
      STEP_BACK: step_state_d = STEP_FIX;
      STEP_FIX:  step_state_d = STEP_IDLE;
      default:   step_state_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    rcp_sel  = (axis_q == REG_SOURCE_WIDTH) ? RcpCol : RcpRow;
    out_sel  = (axis_q == REG_SOURCE_WIDTH) ? DimBits'(OutWidth) : DimBits'(OutHeight);
    back_full = BackW'(quo_q) * BackW'(out_sel);
    rem      = {size_q, FracBits'(0)} - back_q;
    // estimate is at most one below the true quotient
    step_fix = (rem >= AccW'(out_sel)) ? quo_q + AccW'(1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_state_q <= STEP_IDLE;
      col_step_q   <= RstColStep;
      row_step_q   <= RstRowStep;
      eff_w_q      <= RstEffW;
    end else begin
      step_state_q <= step_state_d;
      if (cfg_fire && cfg_index_i == REG_SOURCE_WIDTH) begin
        eff_w_q <= cfg_eff;
      end
      if (step_state_q == STEP_FIX) begin
        if (axis_q == REG_SOURCE_WIDTH) begin
          col_step_q <= step_fix;
        end else begin
          row_step_q <= step_fix;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_fire) begin
      axis_q <= cfg_index_i;
      size_q <= cfg_eff;
    end
    if (step_state_q == STEP_MUL) begin
      prod_q <= ProdW'(size_q) * ProdW'(rcp_sel);
    end
    if (step_state_q == STEP_QUO) begin
      quo_q <= prod_q[RcpShift +: AccW];
    end
    if (step_state_q == STEP_BACK) begin
      back_q <= back_full[AccW-1:0];
    end
  end

  // selection: frame_start clears the counters before this pixel is judged
  always_comb begin
    sc   = in_data_i.frame_start ? '0 : src_col_q;
    sr   = in_data_i.frame_start ? '0 : src_row_q;
    cacc = in_data_i.frame_start ? '0 : col_acc_q;
    racc = in_data_i.frame_start ? '0 : row_acc_q;
    ocol = in_data_i.frame_start ? '0 : out_col_q;
    orow = in_data_i.frame_start ? '0 : out_row_q;

    row_hit = (orow < OrowW'(OutHeight)) && (sr == racc[FracBits +: DimBits]);
    hit     = row_hit && (ocol < OcolW'(OutWidth)) && (sc == cacc[FracBits +: DimBits]);

    res.pixel_out  = in_data_i.pixel_in;
    res.frame_last = (orow == OrowW'(OutHeight - 1)) && (ocol == OcolW'(OutWidth - 1));

    col_acc_d = hit ? cacc + col_step_q : cacc;
    out_col_d = hit ? ocol + OcolW'(1) : ocol;
    row_acc_d = racc;
    out_row_d = orow;
    src_row_d = sr;
    if (sc >= eff_w_q - DimBits'(1)) begin
      src_col_d = '0;
      src_row_d = sr + DimBits'(1);
      if (row_hit) begin
        row_acc_d = racc + row_step_q;
        out_row_d = orow + OrowW'(1);
        out_col_d = '0;
        col_acc_d = '0;
      end
    end else begin
      src_col_d = sc + DimBits'(1);
    end
  end

  assign produce = in_fire && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q    <= '0;
      src_row_q    <= '0;
      col_acc_q    <= '0;
      row_acc_q    <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        src_col_q <= src_col_d;
        src_row_q <= src_row_d;
        col_acc_q <= col_acc_d;
        row_acc_q <= row_acc_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q  <= skid_valid_q || produce;
        skid_valid_q <= 1'b0;
      end else if (produce) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // skid entry catches a result while the output transfer is stalled
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
